FILE: sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, opcodes and transaction types for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int SUM_W       = PROD_W + 1;
    localparam int NUM_W       = PROD_W + FRAC_BITS;
    localparam int DEN_W       = PROD_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    localparam t_data DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [1:0] opcode;
        t_data      first_real;
        t_data      first_imag;
        t_data      second_real;
        t_data      second_imag;
    } t_in_item;

    typedef struct packed {
        t_data result_real;
        t_data result_imag;
        logic  divide_by_zero;
        logic  saturated;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        logic  is_sub;
        logic  is_mul;
        logic  is_div;
        logic  den_zero;
        t_data a;
        t_data b;
        t_data c;
        t_data d;
    } t_cmd;

    // sideband carried alongside the divider pipeline
    typedef struct packed {
        logic                    is_div;
        logic                    den_zero;
        logic                    neg_re;
        logic                    neg_im;
        logic signed [SUM_W-1:0] re_val;
        logic signed [SUM_W-1:0] im_val;
    } t_side;

endpackage

FILE: sv/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Streaming complex add, subtract, multiply and divide in signed Q8.8.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the input is not stalled and returns one
// Q8.8 result per transaction, in order. Every opcode runs through the same
// execution pipeline, including the divider: a pipelined restoring divider
// that resolves one quotient bit per stage. A four-entry command queue
// separates the input side from the execution pipeline, and the whole
// execution pipeline holds while the output is stalled.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    cau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_q_full   (q_full)
    );

    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

FILE: sv/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Accepts input transactions, decodes the opcode and flags a zero divisor.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in,
    output logic     o_push,
    output t_cmd     o_cmd,
    input  logic     i_q_full
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd          = '0;
        n_cmd.a        = i_in.first_real;
        n_cmd.b        = i_in.first_imag;
        n_cmd.c        = i_in.second_real;
        n_cmd.d        = i_in.second_imag;
        unique case (i_in.opcode)
            OP_ADD: begin
            end
            OP_SUB: begin
                n_cmd.is_sub = 1'b1;
            end
            OP_MUL: begin
                n_cmd.is_mul = 1'b1;
            end
            OP_DIV: begin
                n_cmd.is_div   = 1'b1;
                n_cmd.den_zero = (i_in.second_real == '0) && (i_in.second_imag == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: sv/cau_fifo.sv
// ----------------------------------------------------------------------------
// cau_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module cau_fifo
    import cau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];

    // depth is a power of two, so the pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: sv/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor.
// ----------------------------------------------------------------------------
module cau_div
    import cau_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_side                   i_side,
    input  logic signed [SUM_W-1:0] i_num_re,
    input  logic signed [SUM_W-1:0] i_num_im,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic [NUM_W-1:0]        o_quo_re,
    output logic [NUM_W-1:0]        o_quo_im
);

    localparam int STAGES = NUM_W;

    logic             r_vld  [STAGES+1];
    t_side            r_side [STAGES+1];
    logic [NUM_W-1:0] r_nre  [STAGES+1];
    logic [NUM_W-1:0] r_nim  [STAGES+1];
    logic [DEN_W-1:0] r_rre  [STAGES+1];
    logic [DEN_W-1:0] r_rim  [STAGES+1];
    logic [DEN_W-1:0] r_den  [STAGES+1];

    logic signed [SUM_W-1:0] abs_re;
    logic signed [SUM_W-1:0] abs_im;
    t_side                   entry_side;

    // magnitudes fit in PROD_W bits, then scale up by the fraction bits
    assign abs_re = i_num_re[SUM_W-1] ? -i_num_re : i_num_re;
    assign abs_im = i_num_im[SUM_W-1] ? -i_num_im : i_num_im;

    always_comb begin
        entry_side        = i_side;
        entry_side.neg_re = i_num_re[SUM_W-1];
        entry_side.neg_im = i_num_im[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= entry_side;
            r_nre[0]  <= NUM_W'(abs_re[PROD_W-1:0]) << FRAC_BITS;
            r_nim[0]  <= NUM_W'(abs_im[PROD_W-1:0]) << FRAC_BITS;
            r_rre[0]  <= '0;
            r_rim[0]  <= '0;
            r_den[0]  <= i_den;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [DEN_W:0] cat_re;
        logic [DEN_W:0] cat_im;
        logic [DEN_W:0] dif_re;
        logic [DEN_W:0] dif_im;
        logic           ge_re;
        logic           ge_im;

        assign cat_re = {r_rre[k], r_nre[k][NUM_W-1]};
        assign cat_im = {r_rim[k], r_nim[k][NUM_W-1]};
        assign dif_re = cat_re - {1'b0, r_den[k]};
        assign dif_im = cat_im - {1'b0, r_den[k]};
        assign ge_re  = cat_re >= {1'b0, r_den[k]};
        assign ge_im  = cat_im >= {1'b0, r_den[k]};

        // quotient bits shift in where numerator bits leave
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                r_den[k+1]  <= r_den[k];
                r_nre[k+1]  <= {r_nre[k][NUM_W-2:0], ge_re};
                r_nim[k+1]  <= {r_nim[k][NUM_W-2:0], ge_im};
                r_rre[k+1]  <= ge_re ? dif_re[DEN_W-1:0] : cat_re[DEN_W-1:0];
                r_rim[k+1]  <= ge_im ? dif_im[DEN_W-1:0] : cat_im[DEN_W-1:0];
            end
        end
    end

    assign o_valid  = r_vld[STAGES];
    assign o_side   = r_side[STAGES];
    assign o_quo_re = r_nre[STAGES];
    assign o_quo_im = r_nim[STAGES];

endmodule

FILE: sv/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, divider, saturation and output register.
// ----------------------------------------------------------------------------
module cau_back
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic en;

    // stage 1: products and component sums
    logic                       r1_vld;
    logic                       r1_is_mul;
    logic                       r1_is_div;
    logic                       r1_dz;
    logic signed [PROD_W-1:0]   r1_ac;
    logic signed [PROD_W-1:0]   r1_bd;
    logic signed [PROD_W-1:0]   r1_ad;
    logic signed [PROD_W-1:0]   r1_bc;
    logic signed [PROD_W-1:0]   r1_cc;
    logic signed [PROD_W-1:0]   r1_dd;
    logic signed [DATA_WIDTH:0] r1_sre;
    logic signed [DATA_WIDTH:0] r1_sim;

    // stage 2: combined sums
    logic                    r2_vld;
    t_side                   r2_side;
    logic signed [SUM_W-1:0] r2_num_re;
    logic signed [SUM_W-1:0] r2_num_im;
    logic [DEN_W-1:0]        r2_den;
    t_side                   n2_side;
    logic signed [SUM_W-1:0] mul_re;
    logic signed [SUM_W-1:0] mul_im;

    logic             dv_valid;
    t_side            dv_side;
    logic [NUM_W-1:0] dv_quo_re;
    logic [NUM_W-1:0] dv_quo_im;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_pop       = en && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // returns {saturated, value}
    function automatic logic [DATA_WIDTH:0] clip_sum(input logic signed [SUM_W-1:0] v);
        logic [DATA_WIDTH:0] res;
        if (v > SUM_W'(DATA_MAX)) begin
            res = {1'b1, DATA_MAX};
        end else if (v < SUM_W'(DATA_MIN)) begin
            res = {1'b1, DATA_MIN};
        end else begin
            res = {1'b0, v[DATA_WIDTH-1:0]};
        end
        return res;
    endfunction

    function automatic logic [DATA_WIDTH:0] clip_div(input logic [NUM_W-1:0] q,
                                                     input logic neg);
        logic [DATA_WIDTH:0] res;
        logic [NUM_W-1:0]    min_mag;
        min_mag = NUM_W'(1) << (DATA_WIDTH - 1);
        if (!neg && (q > NUM_W'(DATA_MAX))) begin
            res = {1'b1, DATA_MAX};
        end else if (neg && (q > min_mag)) begin
            res = {1'b1, DATA_MIN};
        end else if (neg) begin
            res = {1'b0, -q[DATA_WIDTH-1:0]};
        end else begin
            res = {1'b0, q[DATA_WIDTH-1:0]};
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_q_valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_is_mul <= i_cmd.is_mul;
            r1_is_div <= i_cmd.is_div;
            r1_dz     <= i_cmd.den_zero;
            r1_ac     <= PROD_W'(i_cmd.a) * PROD_W'(i_cmd.c);
            r1_bd     <= PROD_W'(i_cmd.b) * PROD_W'(i_cmd.d);
            r1_ad     <= PROD_W'(i_cmd.a) * PROD_W'(i_cmd.d);
            r1_bc     <= PROD_W'(i_cmd.b) * PROD_W'(i_cmd.c);
            r1_cc     <= PROD_W'(i_cmd.c) * PROD_W'(i_cmd.c);
            r1_dd     <= PROD_W'(i_cmd.d) * PROD_W'(i_cmd.d);
            r1_sre    <= i_cmd.is_sub
                         ? (DATA_WIDTH+1)'(i_cmd.a) - (DATA_WIDTH+1)'(i_cmd.c)
                         : (DATA_WIDTH+1)'(i_cmd.a) + (DATA_WIDTH+1)'(i_cmd.c);
            r1_sim    <= i_cmd.is_sub
                         ? (DATA_WIDTH+1)'(i_cmd.b) - (DATA_WIDTH+1)'(i_cmd.d)
                         : (DATA_WIDTH+1)'(i_cmd.b) + (DATA_WIDTH+1)'(i_cmd.d);
        end
    end

    assign mul_re = SUM_W'(r1_ac) - SUM_W'(r1_bd);
    assign mul_im = SUM_W'(r1_ad) + SUM_W'(r1_bc);

    always_comb begin
        n2_side          = '0;
        n2_side.is_div   = r1_is_div;
        n2_side.den_zero = r1_dz;
        // arithmetic shift gives the floor of the scaled product
        n2_side.re_val   = r1_is_mul ? (mul_re >>> FRAC_BITS) : SUM_W'(r1_sre);
        n2_side.im_val   = r1_is_mul ? (mul_im >>> FRAC_BITS) : SUM_W'(r1_sim);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side   <= n2_side;
            r2_num_re <= SUM_W'(r1_ac) + SUM_W'(r1_bd);
            r2_num_im <= SUM_W'(r1_bc) - SUM_W'(r1_ad);
            r2_den    <= DEN_W'($unsigned(r1_cc)) + DEN_W'($unsigned(r1_dd));
        end
    end

    cau_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r2_vld),
        .i_side   (r2_side),
        .i_num_re (r2_num_re),
        .i_num_im (r2_num_im),
        .i_den    (r2_den),
        .o_valid  (dv_valid),
        .o_side   (dv_side),
        .o_quo_re (dv_quo_re),
        .o_quo_im (dv_quo_im)
    );

    always_comb begin
        logic [DATA_WIDTH:0] cre;
        logic [DATA_WIDTH:0] cim;
        if (dv_side.is_div) begin
            cre = clip_div(dv_quo_re, dv_side.neg_re);
            cim = clip_div(dv_quo_im, dv_side.neg_im);
        end else begin
            cre = clip_sum(dv_side.re_val);
            cim = clip_sum(dv_side.im_val);
        end
        n_out = '0;
        if (dv_side.den_zero) begin
            n_out.divide_by_zero = 1'b1;
        end else begin
            n_out.result_real = cre[DATA_WIDTH-1:0];
            n_out.result_imag = cim[DATA_WIDTH-1:0];
            n_out.saturated   = cre[DATA_WIDTH] || cim[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.divide_by_zero |->
            r_out.result_real == '0 && r_out.result_imag == '0 && !r_out.saturated)
        else $error("divide by zero transaction carries nonzero result");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.saturated |->
            r_out.result_real == DATA_MAX || r_out.result_real == DATA_MIN ||
            r_out.result_imag == DATA_MAX || r_out.result_imag == DATA_MIN)
        else $error("saturated flag without a clipped part");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

FILE: dv/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Watches both channels of the complex arithmetic unit, computes the expected
// result of every accepted transaction and compares the results in order.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_in_count,
    output int        o_out_count,
    output int        o_div_zero_count,
    output int        o_sat_count
);

    t_out_item result_fifo[$];

    function automatic longint floor_shift(longint x);
        // arithmetic shift on a signed value floors
        return x >>> FRAC_BITS;
    endfunction

    function automatic t_data clip_to_data(longint x, inout logic sat);
        longint hi;
        longint lo;
        hi = longint'(DATA_MAX);
        lo = longint'(DATA_MIN);
        if (x > hi) begin
            sat = 1'b1;
            return DATA_MAX;
        end
        if (x < lo) begin
            sat = 1'b1;
            return DATA_MIN;
        end
        return t_data'(x);
    endfunction

    function automatic t_out_item complex_result(t_in_item it);
        t_out_item r;
        longint a, b, c, d, re, im, den;
        logic sat;
        a = longint'(it.first_real);
        b = longint'(it.first_imag);
        c = longint'(it.second_real);
        d = longint'(it.second_imag);
        re = 0;
        im = 0;
        sat = 1'b0;
        r.divide_by_zero = 1'b0;
        case (it.opcode)
            OP_ADD: begin
                re = a + c;
                im = b + d;
            end
            OP_SUB: begin
                re = a - c;
                im = b - d;
            end
            OP_MUL: begin
                re = floor_shift(a * c - b * d);
                im = floor_shift(a * d + b * c);
            end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    // division of signed longints truncates toward zero
                    re = ((a * c + b * d) * (longint'(1) <<< FRAC_BITS)) / den;
                    im = ((b * c - a * d) * (longint'(1) <<< FRAC_BITS)) / den;
                end
            end
        endcase
        r.result_real = clip_to_data(re, sat);
        r.result_imag = clip_to_data(im, sat);
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            result_fifo.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                result_fifo.push_back(complex_result(i_in));
                o_in_count <= o_in_count + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_count <= o_out_count + 1;
                if (result_fifo.size() == 0) begin
                    $error("result with no transaction outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (exp_r.divide_by_zero) o_div_zero_count <= o_div_zero_count + 1;
                    if (exp_r.saturated) o_sat_count <= o_sat_count + 1;
                    if (i_out !== exp_r) begin
                        o_errors <= o_errors + 1;
                        if (i_out.result_real !== exp_r.result_real)
                            $error("result_real expected %0d got %0d",
                                   exp_r.result_real, i_out.result_real);
                        if (i_out.result_imag !== exp_r.result_imag)
                            $error("result_imag expected %0d got %0d",
                                   exp_r.result_imag, i_out.result_imag);
                        if (i_out.divide_by_zero !== exp_r.divide_by_zero)
                            $error("divide_by_zero expected %0b got %0b",
                                   exp_r.divide_by_zero, i_out.divide_by_zero);
                        if (i_out.saturated !== exp_r.saturated)
                            $error("saturated expected %0b got %0b",
                                   exp_r.saturated, i_out.saturated);
                    end
                end
            end
        end
    end

    // leftover count is polled by the top while it waits for the drain
    always_comb o_pending = result_fifo.size();

    initial begin
        o_errors = 0;
        o_in_count = 0;
        o_out_count = 0;
        o_div_zero_count = 0;
        o_sat_count = 0;
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the complex arithmetic unit.
// ----------------------------------------------------------------------------
// Directed corner operands for every opcode, then random transactions with
// random gaps on the input and random stalls on the output. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import cau_pkg::*;

    localparam int N_RANDOM    = 1700;
    localparam int WATCH_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 2 * DATA_WIDTH + FRAC_BITS + 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        errors, pending, in_count, out_count, dz_count, sat_count;
    int        idle_cycles;
    int        stall_hold;
    bit        stall_enable;

    complex_arithmetic_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    cau_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in             (in_item),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out            (out_item),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_in_count       (in_count),
        .o_out_count      (out_count),
        .o_div_zero_count (dz_count),
        .o_sat_count      (sat_count)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic t_data pick_operand();
        case ($urandom_range(0, 9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3: return t_data'($urandom_range(0, 1023)) - t_data'(512);
            4: return t_data'($urandom_range(0, 1) ? 256 : -256);
            default: return t_data'($urandom);
        endcase
    endfunction

    // output stall pattern with a long hold now and then, quiet while
    // stall_enable is clear
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!stall_enable) begin
            stall_hold <= 0;
            out_stall  <= 1'b0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_hold <= $urandom_range(10, 50);
            out_stall  <= 1'b1;
        end else begin
            out_stall  <= (r >= 70);
        end
    end

    // valid stays up after acceptance until the next gap or pause lowers it
    task automatic send_one(t_in_item it);
        int g;
        g = gap_len();
        repeat (g) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_ops(logic [1:0] op, t_data a, t_data b, t_data c, t_data d);
        t_in_item it;
        it.opcode = op;
        it.first_real = a;
        it.first_imag = b;
        it.second_real = c;
        it.second_imag = d;
        send_one(it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCH_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        idle_cycles = 0;
        stall_hold = 0;
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        in_item = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        stall_enable = 1'b1;

        for (int op = 0; op < 4; op++) begin
            send_ops(op[1:0], DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
            send_ops(op[1:0], DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
            send_ops(op[1:0], DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX);
            send_ops(op[1:0], -16'sd384, 16'sd640, 16'sd256, -16'sd512);
            send_ops(op[1:0], 16'sd1, -16'sd1, 16'sd0, -16'sd1);
        end
        // zero divisor, tiny divisor, full-scale quotients
        send_ops(OP_DIV, 16'sd1000, -16'sd77, 16'sd0, 16'sd0);
        send_ops(OP_DIV, DATA_MIN, DATA_MAX, 16'sd0, 16'sd1);
        send_ops(OP_DIV, DATA_MAX, DATA_MAX, 16'sd1, 16'sd0);
        send_ops(OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);

        for (int i = 0; i < N_RANDOM; i++) begin
            it.opcode = 2'($urandom_range(0, 3));
            it.first_real = pick_operand();
            it.first_imag = pick_operand();
            it.second_real = pick_operand();
            it.second_imag = pick_operand();
            if ($urandom_range(0, 19) == 0) begin
                it.second_real = '0;
                it.second_imag = '0;
            end
            send_one(it);
            // let the pipeline empty completely once mid-run
            if (i == N_RANDOM / 2) begin
                in_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        stall_enable = 1'b0;
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("%0d transactions sent, %0d results checked", in_count, out_count);
        $display("%0d divide-by-zero and %0d saturated results seen", dz_count, sat_count);
        if (errors == 0 && pending == 0 && in_count == out_count) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: complex_arithmetic_unit.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_fifo.sv
sv/cau_div.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
dv/cau_checker.sv
dv/tb_top.sv
